@@ rtl/lcfh_pkg.sv @@
`timescale 1ns / 1ps

package lcfh_pkg;

    typedef logic [7:0] level_t;

    // Kind of an input item, carried on the slave-side tuser.
    typedef enum logic
    {
        ACT_BYTE = 1'b0,
        ACT_IDLE = 1'b1
    } action_t;

    localparam level_t RX_START_CODE = 8'h0C;
    localparam level_t RX_END_CODE   = 8'h0A;
    localparam level_t TX_START_CODE = 8'h1C;
    localparam level_t TX_END_CODE   = 8'h1A;

    // Width of the frame byte counter, which stops at 256; later bytes are dropped.
    localparam int unsigned COUNT_W = 9;

endpackage

@@ rtl/lcfh_frame.sv @@
`timescale 1ns / 1ps

module lcfh_frame #(
    parameter int unsigned NUM_LEDS = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  lcfh_pkg::action_t                   s_tuser,
    input  logic                                reply_busy,
    output logic                                reply_start,
    output logic [NUM_LEDS-1:0][7:0]            led_levels
);
    import lcfh_pkg::*;

    localparam int unsigned LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    logic                         in_valid_reg;
    action_t                      in_action_reg;
    level_t                       in_byte_reg;
    logic                         advance;

    logic [COUNT_W-1:0]           count_reg, count_next;
    level_t                       sum_reg, sum_next;
    level_t                       first_reg, first_next;
    level_t                       len_reg, len_next;
    level_t                       last_reg, last_next;
    level_t                       second_reg, second_next;
    level_t                       pend_index_reg, pend_index_next;
    level_t                       pend_level_reg, pend_level_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [NUM_LEDS-1:0][7:0]     shadow_reg, shadow_next;
    logic [NUM_LEDS-1:0][7:0]     levels_reg, levels_next;
    logic                         frame_ok;
    level_t                       earlier_sum;

    // An end-of-frame item waits in the input register until the reply unit is free.
    assign advance  = in_valid_reg && ((in_action_reg == ACT_BYTE) || !reply_busy);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    assign earlier_sum = sum_reg - last_reg;
    assign frame_ok    = !count_reg[COUNT_W-1] && (count_reg >= COUNT_W'(4))
                         && (len_reg == count_reg[7:0])
                         && (first_reg == RX_START_CODE)
                         && (second_reg == RX_END_CODE)
                         && (last_reg == earlier_sum);

    always_comb
    begin
        count_next      = count_reg;
        sum_next        = sum_reg;
        first_next      = first_reg;
        len_next        = len_reg;
        last_next       = last_reg;
        second_next     = second_reg;
        pend_index_next = pend_index_reg;
        pend_level_next = pend_level_reg;
        pend_valid_next = pend_valid_reg;
        shadow_next     = shadow_reg;
        levels_next     = levels_reg;
        reply_start     = 1'b0;
        if (advance)
        begin
            if (in_action_reg == ACT_BYTE)
            begin
                if (!count_reg[COUNT_W-1])
                begin
                    if (count_reg == COUNT_W'(0))
                    begin
                        first_next = in_byte_reg;
                    end
                    else if (count_reg == COUNT_W'(1))
                    begin
                        len_next = in_byte_reg;
                    end
                    else if (!count_reg[0])
                    begin
                        if ((count_reg >= COUNT_W'(4)) && pend_valid_reg
                            && (pend_index_reg < 8'(NUM_LEDS)))
                        begin
                            shadow_next[pend_index_reg[LED_W-1:0]] = pend_level_reg;
                        end
                        pend_index_next = in_byte_reg;
                        pend_valid_next = 1'b1;
                    end
                    else
                    begin
                        pend_level_next = in_byte_reg;
                    end
                    sum_next    = sum_reg + in_byte_reg;
                    second_next = last_reg;
                    last_next   = in_byte_reg;
                    count_next  = count_reg + COUNT_W'(1);
                end
            end
            else
            begin
                // The shadow always ends up equal to the committed levels.
                if (frame_ok)
                begin
                    levels_next = shadow_reg;
                    reply_start = 1'b1;
                end
                else
                begin
                    shadow_next = levels_reg;
                end
                count_next      = '0;
                sum_next        = '0;
                first_next      = '0;
                len_next        = '0;
                last_next       = '0;
                second_next     = '0;
                pend_index_next = '0;
                pend_level_next = '0;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sum_reg        <= '0;
            first_reg      <= '0;
            len_reg        <= '0;
            last_reg       <= '0;
            second_reg     <= '0;
            pend_index_reg <= '0;
            pend_level_reg <= '0;
            pend_valid_reg <= 1'b0;
            shadow_reg     <= '0;
            levels_reg     <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            first_reg      <= first_next;
            len_reg        <= len_next;
            last_reg       <= last_next;
            second_reg     <= second_next;
            pend_index_reg <= pend_index_next;
            pend_level_reg <= pend_level_next;
            pend_valid_reg <= pend_valid_next;
            shadow_reg     <= shadow_next;
            levels_reg     <= levels_next;
        end
    end

    assign led_levels = levels_reg;

endmodule

@@ rtl/lcfh_reply.sv @@
`timescale 1ns / 1ps

module lcfh_reply #(
    parameter int unsigned NUM_LEDS = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        reply_start,
    input  logic [NUM_LEDS-1:0][7:0]    led_levels,
    output logic                        reply_busy,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    output logic                        m_tlast
);
    import lcfh_pkg::*;

    localparam int unsigned REPLY_LEN = 2 * NUM_LEDS + 4;
    localparam int unsigned IDX_W     = $clog2(REPLY_LEN);
    localparam int unsigned LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLY_LEN - 1);
    localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(REPLY_LEN - 2);

    logic                 active_reg, active_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    level_t               sum_reg, sum_next;
    logic                 out_valid_reg, out_valid_next;
    level_t               out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic [2:0]           out_mask_reg, out_mask_next;
    logic                 load;
    logic [IDX_W-1:0]     lane;
    level_t               cur_byte;
    level_t               lane_level;
    logic [2:0]           cur_mask;

    assign load = active_reg && (!out_valid_reg || m_tready);
    assign lane = (idx_reg >> 1) - IDX_W'(1);

    always_comb
    begin
        lane_level = '0;
        if (lane < IDX_W'(NUM_LEDS))
        begin
            lane_level = led_levels[lane[LED_W-1:0]];
        end
    end

    always_comb
    begin
        if (idx_reg == IDX_W'(0))
        begin
            cur_byte = TX_START_CODE;
        end
        else if (idx_reg == IDX_W'(1))
        begin
            cur_byte = 8'(REPLY_LEN);
        end
        else if (idx_reg == END_IDX)
        begin
            cur_byte = TX_END_CODE;
        end
        else if (idx_reg == LAST_IDX)
        begin
            cur_byte = sum_reg;
        end
        else if (!idx_reg[0])
        begin
            cur_byte = 8'(lane);
        end
        else
        begin
            cur_byte = lane_level;
        end
    end

    always_comb
    begin
        cur_mask = '0;
        for (int i = 0; i < 3 && i < NUM_LEDS; i++)
        begin
            cur_mask[i] = |led_levels[i];
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_mask_next  = out_mask_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (reply_start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            sum_next    = '0;
        end
        else if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = (idx_reg == LAST_IDX);
            out_mask_next  = cur_mask;
            sum_next       = sum_reg + cur_byte;
            idx_next       = idx_reg + IDX_W'(1);
            if (idx_reg == LAST_IDX)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_mask_reg <= out_mask_next;
    end

    assign reply_busy = active_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {5'b0, out_mask_reg, out_byte_reg};
    assign m_tlast    = out_last_reg;

endmodule

@@ rtl/led_command_frame_handler_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Signals                      | Contents
// ---------+-----------+------------------------------+--------------------------------------
// s_       | in        | tvalid tready tdata tuser    | tdata: rx_byte; tuser: action
// m_       | out       | tvalid tready tdata tlast    | tdata: tx_byte, led_on_mask; tlast
//
// A received byte is taken every cycle while no end-of-frame item waits at the input, and
// reaches the state in the next cycle. An end-of-frame item on a valid frame yields a reply of
// 2*NUM_LEDS+4 items, one per cycle from the reply counter unless m_tready stalls; the next
// end-of-frame item waits until that counter is done. Items leave through the output register.
// rst_n clears the frame state and all LED levels at once; no clearing pass is needed.
// A stall on m_tready holds the output register and the reply counter; received bytes keep
// flowing until a following end-of-frame item, which waits at the input with the bytes behind it.
module led_command_frame_handler_unit #(
    parameter int unsigned NUM_LEDS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] rx_byte
    input  lcfh_pkg::action_t  s_tuser,    // [0] action
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,    // [7:0] tx_byte, [10:8] led_on_mask, [15:11] zero
    output logic               m_tlast
);
    import lcfh_pkg::*;

    logic                        reply_busy;
    logic                        reply_start;
    logic [NUM_LEDS-1:0][7:0]    led_levels;

    lcfh_frame #(
        .NUM_LEDS (NUM_LEDS)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .reply_busy  (reply_busy),
        .reply_start (reply_start),
        .led_levels  (led_levels)
    );

    lcfh_reply #(
        .NUM_LEDS (NUM_LEDS)
    ) u_reply (
        .clk         (clk),
        .rst_n       (rst_n),
        .reply_start (reply_start),
        .led_levels  (led_levels),
        .reply_busy  (reply_busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

@@ rtl/lcfh_checker.sv @@
`timescale 1ns / 1ps

module lcfh_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  lcfh_pkg::action_t  s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [15:0]        m_tdata,
    input  logic               m_tlast
);
    import lcfh_pkg::*;

    // A waiting input item holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting input item changed");

    // A stalled output item holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    // Inside a reply the items come without gaps and the LED mask does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast
        |=> m_tvalid && (m_tdata[10:8] == $past(m_tdata[10:8])))
        else $error("reply broken or mask changed inside a reply");

    // After the checksum item, the next item opens a new reply.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[7:0] == TX_START_CODE))
        else $error("reply does not start with the start code");

    // The pad bits of the output data are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:11] == 5'b0))
        else $error("pad bits of output data set");

endmodule

bind led_command_frame_handler_unit lcfh_checker u_lcfh_checker (.*);
